// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Entry layout, control word between the top level and the cells, status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int VAL_W      = 32;
  localparam int PRI_W      = 32;
  localparam int COUNT_W    = 5;
  localparam int STAT_W     = 2;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 136;

  typedef struct packed {
    logic        [VAL_W-1:0] value;
    logic signed [PRI_W-1:0] prio;
  } entry_t;

  // one operation strobe per cycle, shared by every cell
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_ctl_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbor; on remove it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      slot_valid, // slot lies below the entry count
  input  entry_t    new_ent,
  input  logic      left_here,  // left neighbor is at or past the insert point
  input  entry_t    left_ent,
  input  entry_t    right_ent,
  output logic      here,       // this slot is at or past the insert point
  output entry_t    ent
);

  entry_t ent_r;
  entry_t ent_nxt;

  assign here = !slot_valid || ($signed(ent_r.prio) > $signed(new_ent.prio));
  assign ent  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins_en) begin
      if (left_here) begin
        ent_nxt = left_ent;
      end else if (here) begin
        ent_nxt = new_ent;
      end
    end else if (ctl.rem_en) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue: sorted-list priority queue on a chain of cells
// Keeps up to DEPTH entries ordered by signed priority, lowest first.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry one operation each. in_tuser[0] selects insert (0) or
//   remove-first (1); in_tdata holds the value handle and the priority of an
//   entry to insert (ignored on remove).
//   Every accepted word yields exactly one output word: the removed entry,
//   the head after the operation, an empty flag, the entry count and status.
//   An insert into a full queue is dropped with status 1; a remove from an
//   empty queue leaves the queue alone with status 2.
// Timing:
//   One operation per cycle. Each cell compares its priority against the
//   incoming one and shifts with its neighbors in the same cycle, so the
//   result is registered one cycle after acceptance and the next word may
//   be taken in that very cycle.
// Reset:
//   rst_n (synchronous, low) empties the queue and the output register; the
//   cell contents are left as they are and are never read below the count.
// Stall:
//   While out_tready is low the result is held and in_tready drops, so no
//   word is lost; in_tready returns as soon as the result is taken.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // item_value[31:0], item_priority[63:32]
  input  logic                  in_tuser,  // mode

  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata  // removed_value, removed_priority,
                                           // head_value, head_priority,
                                           // is_empty, entry_count[4:0],
                                           // status[1:0]
);

  logic                  accept;
  mode_t                 mode;
  entry_t                new_ent;
  cell_ctl_t             ctl;
  logic                  full;
  logic                  empty;

  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  entry_t                cell_ent [DEPTH];
  logic                  cell_here [DEPTH];

  entry_t                rem_ent;
  entry_t                head_ent;
  status_t               status;

  // the output register frees up when its word is taken this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign mode          = mode_t'(in_tuser);
  assign new_ent.value = in_tdata[31:0];
  assign new_ent.prio  = in_tdata[63:32];

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  assign ctl.ins_en = accept && (mode == MODE_INSERT) && !full;
  assign ctl.rem_en = accept && (mode == MODE_REMOVE) && !empty;

  // chain of cells: left end is the head of the queue
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic   left_here;
    entry_t left_ent;
    entry_t right_ent;

    if (i == 0) begin : g_head
      assign left_here = 1'b0;
      assign left_ent  = new_ent;
    end else begin : g_mid
      assign left_here = cell_here[i-1];
      assign left_ent  = cell_ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_ent = cell_ent[i];
    end else begin : g_body
      assign right_ent = cell_ent[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .slot_valid (IDX < count_r),
      .new_ent    (new_ent),
      .left_here  (left_here),
      .left_ent   (left_ent),
      .right_ent  (right_ent),
      .here       (cell_here[i]),
      .ent        (cell_ent[i])
    );
  end

  // result word and count update
  always_comb begin
    count_nxt = count_r;
    rem_ent   = '0;
    head_ent  = cell_ent[0];
    status    = ST_OK;

    if (ctl.ins_en) begin
      count_nxt = count_r + CNT_W'(1);
      if (cell_here[0]) begin
        head_ent = new_ent;
      end
    end else if (ctl.rem_en) begin
      count_nxt = count_r - CNT_W'(1);
      rem_ent   = cell_ent[0];
      head_ent  = cell_ent[1];
    end

    if (accept && (mode == MODE_INSERT) && full) begin
      status = ST_FULL;
    end else if (accept && (mode == MODE_REMOVE) && empty) begin
      status = ST_EMPTY;
    end

    // zero the head when nothing remains
    if (count_nxt == '0) begin
      head_ent = '0;
    end

    out_data_nxt  = {status,
                     COUNT_W'(count_nxt),
                     (count_nxt == '0),
                     head_ent.prio,
                     head_ent.value,
                     rem_ent.prio,
                     rem_ent.value};

    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
